FILE: rtl/u8pc_pkg.sv
// Shared types and constants for the strict UTF-8 document pre-check.
`timescale 1ns / 1ps
package u8pc_pkg;

    localparam int OFFSET_W = 24;
    localparam int COUNT_W  = 25;
    localparam int LIMIT_W  = 24;
    localparam int ADDR_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

    // Register index as decoded from paddr[2].
    localparam logic CFG_IDX_MAX_BYTES = 1'b0;

    typedef enum logic [2:0] {
        V_OK        = 3'd0,
        V_TOO_LARGE = 3'd1,
        V_RAW_NUL   = 3'd2,
        V_BOM       = 3'd3,
        V_BAD_UTF8  = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_item;
    } t_item;

    typedef struct packed {
        t_verdict              verdict;
        logic [OFFSET_W-1:0]   error_offset;
    } t_result;

endpackage

FILE: rtl/strict_utf8_document_precheck_core.sv
// Top level of the strict UTF-8 document pre-check.
//
// Documents arrive one byte per beat on the slave stream; tlast ends a document and
// tuser says whether the beat carries a byte (a beat with tuser low and tlast high
// closes a document without adding a byte). Each byte passes an input register and
// one stage of scan logic, so a new beat is taken every cycle but for the stall below.
// The verdict is registered in the output register when the last beat fires. The only
// stall is a last beat waiting while the previous verdict is still held by the
// output register. Verdicts: 0 ok, 1 longer than the limit register, 2 raw NUL (with
// its offset), 3 leading byte order mark, 4 invalid UTF-8 (offset of the lead byte).
// The limit register sits at APB address 0 and resets to 16777215.
`timescale 1ns / 1ps
module strict_utf8_document_precheck_core
    import u8pc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tuser,   // [0] byte_present
    input  logic              s_axis_tlast,   // last_item
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [2:0] verdict, [26:3] error_offset, rest 0
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [LIMIT_W-1:0] max_bytes;
    t_item              in_item;
    t_item              st_item;
    logic               fire;
    logic               out_free;
    logic               res_valid;
    t_result            res;
    t_result            out_res;

    u8pc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_bytes (max_bytes)
    );

    assign in_item.data_byte    = s_axis_tdata;
    assign in_item.byte_present = s_axis_tuser;
    assign in_item.last_item    = s_axis_tlast;

    u8pc_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_fire     (fire),
        .o_item     (st_item)
    );

    u8pc_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (st_item),
        .i_max_bytes (max_bytes),
        .o_res_valid (res_valid),
        .o_result    (res)
    );

    u8pc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (res),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res)
    );

    assign m_axis_tdata = {{(32-OFFSET_W-3){1'b0}}, out_res.error_offset, out_res.verdict};

endmodule

FILE: rtl/u8pc_cfg.sv
// APB register file holding the document length limit.
`timescale 1ns / 1ps
module u8pc_cfg
    import u8pc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [LIMIT_W-1:0] o_max_bytes
);

    logic [LIMIT_W-1:0] r_max;
    logic [LIMIT_W-1:0] n_max;
    logic               w_hit;

    assign pready = 1'b1;
    assign w_hit  = psel && penable && pwrite && (paddr[2] == CFG_IDX_MAX_BYTES);

    always_comb begin
        n_max = r_max;
        if (w_hit) begin
            n_max = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= LIMIT_RESET;
        end else begin
            r_max <= n_max;
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_MAX_BYTES) ? {{(32-LIMIT_W){1'b0}}, r_max} : 32'd0;
    assign o_max_bytes = r_max;

endmodule

FILE: rtl/u8pc_in_reg.sv
// Input register stage for document byte beats.
`timescale 1ns / 1ps
module u8pc_in_reg
    import u8pc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_out_free,
    output logic  o_fire,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // A last beat produces a verdict, so it waits until the result slot frees up.
    assign o_fire  = r_valid && (!r_item.last_item || i_out_free);
    assign o_ready = !r_valid || o_fire;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: rtl/u8pc_scan.sv
// Per-byte scan state: length count, NUL search, BOM match and UTF-8 decoder.
`timescale 1ns / 1ps
module u8pc_scan
    import u8pc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_item              i_item,
    input  logic [LIMIT_W-1:0] i_max_bytes,
    output logic               o_res_valid,
    output t_result            o_result
);

    typedef enum logic [2:0] {
        CLS_ANY   = 3'd0,
        CLS_A0_BF = 3'd1,
        CLS_80_9F = 3'd2,
        CLS_90_BF = 3'd3,
        CLS_80_8F = 3'd4
    } t_cont_cls;

    function automatic logic cont_ok(input t_cont_cls cls, input logic [7:0] b);
        logic ok;
        unique case (cls)
            CLS_A0_BF: ok = (b >= 8'ha0) && (b <= 8'hbf);
            CLS_80_9F: ok = (b >= 8'h80) && (b <= 8'h9f);
            CLS_90_BF: ok = (b >= 8'h90) && (b <= 8'hbf);
            CLS_80_8F: ok = (b >= 8'h80) && (b <= 8'h8f);
            default:   ok = (b >= 8'h80) && (b <= 8'hbf);
        endcase
        return ok;
    endfunction

    logic [COUNT_W-1:0]  r_count,     n_count;
    logic                r_nul_seen,  n_nul_seen;
    logic [OFFSET_W-1:0] r_nul_off,   n_nul_off;
    logic                r_failed,    n_failed;
    logic [OFFSET_W-1:0] r_fail_off,  n_fail_off;
    logic [1:0]          r_pending,   n_pending;
    t_cont_cls           r_cls,       n_cls;
    logic [OFFSET_W-1:0] r_lead_off,  n_lead_off;
    logic [1:0]          r_mark,      n_mark;

    logic [7:0]          b;
    logic [OFFSET_W-1:0] off;
    t_verdict            verdict;
    logic [OFFSET_W-1:0] res_off;

    assign b   = i_item.data_byte;
    assign off = r_count[OFFSET_W-1:0];

    always_comb begin
        n_count    = r_count;
        n_nul_seen = r_nul_seen;
        n_nul_off  = r_nul_off;
        n_failed   = r_failed;
        n_fail_off = r_fail_off;
        n_pending  = r_pending;
        n_cls      = r_cls;
        n_lead_off = r_lead_off;
        n_mark     = r_mark;

        if (i_item.byte_present) begin
            if ((b == 8'h00) && !r_nul_seen) begin
                n_nul_seen = 1'b1;
                n_nul_off  = off;
            end

            if ((r_count == COUNT_W'(0)) && (b == 8'hef)) begin
                n_mark = 2'd1;
            end else if ((r_count == COUNT_W'(1)) && (r_mark == 2'd1) && (b == 8'hbb)) begin
                n_mark = 2'd2;
            end else if ((r_count == COUNT_W'(2)) && (r_mark == 2'd2) && (b == 8'hbf)) begin
                n_mark = 2'd3;
            end

            if (!r_failed) begin
                priority if (r_pending != 2'd0) begin
                    if (cont_ok(r_cls, b)) begin
                        n_pending = r_pending - 2'd1;
                        n_cls     = CLS_ANY;
                    end else begin
                        n_failed   = 1'b1;
                        n_fail_off = r_lead_off;
                        n_pending  = 2'd0;
                        n_cls      = CLS_ANY;
                    end
                end else if (b <= 8'h7f) begin
                    n_pending = 2'd0;
                end else if ((b >= 8'hc2) && (b <= 8'hdf)) begin
                    n_pending  = 2'd1;
                    n_cls      = CLS_ANY;
                    n_lead_off = off;
                end else if ((b >= 8'he0) && (b <= 8'hef)) begin
                    n_pending  = 2'd2;
                    n_cls      = (b == 8'he0) ? CLS_A0_BF :
                                 (b == 8'hed) ? CLS_80_9F : CLS_ANY;
                    n_lead_off = off;
                end else if ((b >= 8'hf0) && (b <= 8'hf4)) begin
                    n_pending  = 2'd3;
                    n_cls      = (b == 8'hf0) ? CLS_90_BF :
                                 (b == 8'hf4) ? CLS_80_8F : CLS_ANY;
                    n_lead_off = off;
                end else begin
                    n_failed   = 1'b1;
                    n_fail_off = off;
                    n_pending  = 2'd0;
                    n_cls      = CLS_ANY;
                end
            end

            if (r_count != COUNT_MAX) begin
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    // Verdict for a document that ends with this beat; a sequence still open is truncated.
    always_comb begin
        verdict = V_OK;
        res_off = '0;
        priority if (n_count > {{(COUNT_W-LIMIT_W){1'b0}}, i_max_bytes}) begin
            verdict = V_TOO_LARGE;
        end else if (n_nul_seen) begin
            verdict = V_RAW_NUL;
            res_off = n_nul_off;
        end else if (n_mark == 2'd3) begin
            verdict = V_BOM;
        end else if (n_failed) begin
            verdict = V_BAD_UTF8;
            res_off = n_fail_off;
        end else if (n_pending != 2'd0) begin
            verdict = V_BAD_UTF8;
            res_off = n_lead_off;
        end else begin
            verdict = V_OK;
        end
    end

    assign o_res_valid           = i_fire && i_item.last_item;
    assign o_result.verdict      = verdict;
    assign o_result.error_offset = res_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_item)) begin
            r_count    <= '0;
            r_nul_seen <= 1'b0;
            r_nul_off  <= '0;
            r_failed   <= 1'b0;
            r_fail_off <= '0;
            r_pending  <= 2'd0;
            r_cls      <= CLS_ANY;
            r_lead_off <= '0;
            r_mark     <= 2'd0;
        end else if (i_fire) begin
            r_count    <= n_count;
            r_nul_seen <= n_nul_seen;
            r_nul_off  <= n_nul_off;
            r_failed   <= n_failed;
            r_fail_off <= n_fail_off;
            r_pending  <= n_pending;
            r_cls      <= n_cls;
            r_lead_off <= n_lead_off;
            r_mark     <= n_mark;
        end
    end

`ifndef SYNTH
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.last_item) |=> (r_count == '0 && !r_failed && r_pending == 2'd0))
        else $error("scan state not cleared after a last beat");

    a_failed_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> (r_pending == 2'd0))
        else $error("continuations pending after a UTF-8 fault");

    a_mark_needs_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mark == 2'd3) |-> (r_count >= COUNT_W'(3)))
        else $error("byte order mark matched with fewer than three bytes");

    a_nul_before_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nul_seen |-> ({{(COUNT_W-OFFSET_W){1'b0}}, r_nul_off} < r_count))
        else $error("NUL offset not below the byte count");
`endif

endmodule

FILE: rtl/u8pc_out_reg.sv
// Result register holding one verdict beat until it is taken.
`timescale 1ns / 1ps
module u8pc_out_reg
    import u8pc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
